### sv/dws_pkg.sv
// ---------------------------------------------------------------------------
// dws_pkg
// Shared constants and controller/datapath types for the wave stencil block.
// ---------------------------------------------------------------------------
package dws_pkg;

   localparam int MAX_COLS_DEF = 256;
   localparam int MAX_ROWS_DEF = 256;

   localparam int DISP_W  = 32;
   localparam int SPEED_W = 16;
   localparam int DAMP_W  = 17;
   localparam int COORD_W = 8;

   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 9;

   localparam logic [CSR_IDX_W-1:0] REG_GRID_WIDTH  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_HEIGHT = 4'd1;

   localparam logic [CSR_DATA_W-1:0] GRID_DIM_RESET = 9'd256;

   localparam logic [1:0] JOB_UPPER = 2'd0;
   localparam logic [1:0] JOB_LEFT  = 2'd1;
   localparam logic [1:0] JOB_LAST  = 2'd2;

   typedef struct packed {
      logic       accept;
      logic       rd_next;
      logic       cap_cur;
      logic       cap_next;
      logic       load;
      logic [1:0] job;
      logic       lap;
      logic       mul1;
      logic       sum;
      logic       mul2;
      logic       emit;
      logic       finish;
   } cmd_type;

   typedef struct packed {
      logic has_upper;
      logic has_left;
      logic has_last;
      logic rsp_taken;
   } sts_type;

endpackage

### sv/dws_req_if.sv
// ---------------------------------------------------------------------------
// dws_req_if
// Input cell channel: valid/ready with one grid cell as payload.
// ---------------------------------------------------------------------------
interface dws_req_if;
   logic                        valid;
   logic                        ready;
   logic signed [31:0]          disp_now;
   logic signed [31:0]          disp_before;
   logic [15:0]                 speed_sq;
   logic [16:0]                 damp_factor;

   modport source (output valid, disp_now, disp_before, speed_sq, damp_factor,
                   input ready);
   modport sink   (input valid, disp_now, disp_before, speed_sq, damp_factor,
                   output ready);
endinterface

### sv/dws_rsp_if.sv
// ---------------------------------------------------------------------------
// dws_rsp_if
// Result channel: valid/ready with one updated cell as payload.
// ---------------------------------------------------------------------------
interface dws_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [7:0]                  out_col;
   logic [7:0]                  out_row;
   logic signed [31:0]          disp_next;
   logic signed [31:0]          disp_old;
   logic                        grid_done;

   modport source (output valid, out_col, out_row, disp_next, disp_old, grid_done,
                   input ready);
   modport sink   (input valid, out_col, out_row, disp_next, disp_old, grid_done,
                   output ready);
endinterface

### sv/damped_wave_stencil_2d.sv
// ---------------------------------------------------------------------------
// damped_wave_stencil_2d
// One damped five-point wave-equation step over a raster stream of cells.
//
// Cells enter on req_ch (valid/ready) row by row, column by column. Each cell
// completes the stencil of the cell above it, so results trail the input by
// one grid row; in the last row one cell yields up to three results, the
// very last one flagged grid_done. Results leave on rsp_ch (valid/ready).
// Geometry is set through csr_we/csr_index/csr_wdata while idle; any geometry
// write restarts the pass at row 0, column 0.
// One cell is handled at a time and yields 0 to 3 results. Each cell passes
// three line-buffer read states and then, for each result, a shared five-step
// multiply/round unit.
// A stalled receiver holds the result register and the block waits; req_ch
// stays not ready until the cell's last result has been taken.
// Reset (synchronous, active high) sets the grid to 256 x 256 and the
// position to the origin; line buffers need no clearing.
// ---------------------------------------------------------------------------
module damped_wave_stencil_2d #(
   parameter int MAX_COLS = dws_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = dws_pkg::MAX_ROWS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   dws_req_if.sink                        req_ch,
   dws_rsp_if.source                      rsp_ch,
   input  logic                           csr_we,
   input  logic [dws_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dws_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import dws_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic    req_ready;

   assign req_ch.ready = req_ready;

   dws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   dws_datapath #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .cmd            (cmd),
      .sts            (sts),
      .in_disp_now    (req_ch.disp_now),
      .in_disp_before (req_ch.disp_before),
      .in_speed_sq    (req_ch.speed_sq),
      .in_damp_factor (req_ch.damp_factor),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .rsp_out_col    (rsp_ch.out_col),
      .rsp_out_row    (rsp_ch.out_row),
      .rsp_disp_next  (rsp_ch.disp_next),
      .rsp_disp_old   (rsp_ch.disp_old),
      .rsp_grid_done  (rsp_ch.grid_done)
   );

   a_no_accept_with_result: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |-> !rsp_ch.valid)
      else $error("item accepted while a result is pending");

   a_busy_while_result: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !req_ch.ready)
      else $error("input ready while a result waits");

   a_emit_follows_mul: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> $past(cmd.mul2))
      else $error("result emitted without a completed product");

   a_one_phase: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.accept, cmd.load, cmd.emit, cmd.finish}))
      else $error("conflicting controller commands");
endmodule

### sv/dws_ram.sv
// ---------------------------------------------------------------------------
// dws_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module dws_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

### sv/dws_ctrl.sv
// ---------------------------------------------------------------------------
// dws_ctrl
// Sequencer: accept a cell, read the line buffers, then run each result
// through the shared arithmetic unit and hand it to the result register.
// ---------------------------------------------------------------------------
module dws_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dws_pkg::sts_type sts,
   output dws_pkg::cmd_type cmd
);
   import dws_pkg::*;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_RD0  = 4'd1;
   localparam logic [3:0] ST_RD1  = 4'd2;
   localparam logic [3:0] ST_RD2  = 4'd3;
   localparam logic [3:0] ST_PICK = 4'd4;
   localparam logic [3:0] ST_LAP  = 4'd5;
   localparam logic [3:0] ST_MUL1 = 4'd6;
   localparam logic [3:0] ST_SUM  = 4'd7;
   localparam logic [3:0] ST_MUL2 = 4'd8;
   localparam logic [3:0] ST_OUT  = 4'd9;
   localparam logic [3:0] ST_WAIT = 4'd10;
   localparam logic [3:0] ST_FIN  = 4'd11;

   logic [3:0] state_ff, state_in;
   logic [2:0] jobs_ff, jobs_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         jobs_ff  <= 3'b000;
      end else begin
         state_ff <= state_in;
         jobs_ff  <= jobs_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      jobs_in  = jobs_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_RD0;
            end
         end
         ST_RD0: state_in = ST_RD1;
         ST_RD1: begin
            cmd.cap_cur = 1'b1;
            cmd.rd_next = 1'b1;
            state_in    = ST_RD2;
         end
         ST_RD2: begin
            cmd.cap_next = 1'b1;
            jobs_in      = {sts.has_last, sts.has_left, sts.has_upper};
            state_in     = ST_PICK;
         end
         ST_PICK: begin
            priority if (jobs_ff[0]) begin
               cmd.load   = 1'b1;
               cmd.job    = JOB_UPPER;
               jobs_in[0] = 1'b0;
               state_in   = ST_LAP;
            end else if (jobs_ff[1]) begin
               cmd.load   = 1'b1;
               cmd.job    = JOB_LEFT;
               jobs_in[1] = 1'b0;
               state_in   = ST_LAP;
            end else if (jobs_ff[2]) begin
               cmd.load   = 1'b1;
               cmd.job    = JOB_LAST;
               jobs_in[2] = 1'b0;
               state_in   = ST_LAP;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_LAP: begin
            cmd.lap  = 1'b1;
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            cmd.emit = 1'b1;
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (sts.rsp_taken) begin
               state_in = ST_PICK;
            end
         end
         ST_FIN: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

### sv/dws_datapath.sv
// ---------------------------------------------------------------------------
// dws_datapath
// Grid counters, line buffers, neighbor registers, stencil arithmetic and
// the result register.
// ---------------------------------------------------------------------------
module dws_datapath #(
   parameter int MAX_COLS = dws_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = dws_pkg::MAX_ROWS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [dws_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [dws_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  dws_pkg::cmd_type                     cmd,
   output dws_pkg::sts_type                     sts,
   input  logic signed [dws_pkg::DISP_W-1:0]    in_disp_now,
   input  logic signed [dws_pkg::DISP_W-1:0]    in_disp_before,
   input  logic [dws_pkg::SPEED_W-1:0]          in_speed_sq,
   input  logic [dws_pkg::DAMP_W-1:0]           in_damp_factor,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [dws_pkg::COORD_W-1:0]          rsp_out_col,
   output logic [dws_pkg::COORD_W-1:0]          rsp_out_row,
   output logic signed [dws_pkg::DISP_W-1:0]    rsp_disp_next,
   output logic signed [dws_pkg::DISP_W-1:0]    rsp_disp_old,
   output logic                                 rsp_grid_done
);
   import dws_pkg::*;

   localparam int AW = $clog2(MAX_COLS);
   localparam int RW = $clog2(MAX_ROWS);
   localparam int PW = DISP_W + SPEED_W + DAMP_W;

   // geometry and counters
   logic [CSR_DATA_W-1:0] width_ff, height_ff;
   logic [AW-1:0]         col_ff, col_in;
   logic [RW-1:0]         row_ff, row_in;
   logic [31:0]           w_raw, h_raw, w_eff, h_eff;
   logic [31:0]           col32, row32, c32, r32;

   // current cell
   logic [AW-1:0]              cur_c_ff;
   logic [RW-1:0]              cur_r_ff;
   logic signed [DISP_W-1:0]   cu_ff, cp_ff;
   logic [SPEED_W-1:0]         cs_ff;
   logic [DAMP_W-1:0]          cd_ff;

   // buffer reads and neighbor history
   logic signed [DISP_W-1:0]   upper_c_ff, lower_c_ff, bef_c_ff, upper_c1_ff;
   logic [SPEED_W-1:0]         spd_c_ff;
   logic [DAMP_W-1:0]          dmp_c_ff;
   logic signed [DISP_W-1:0]   prev_cu_ff, prev2_cu_ff, prev_cp_ff, prev_low_ff;
   logic [SPEED_W-1:0]         prev_cs_ff;
   logic [DAMP_W-1:0]          prev_cd_ff;

   // RAM ports
   logic [AW-1:0]          raddr;
   logic [DISP_W-1:0]      upper_rdata, lower_rdata;
   logic [PW-1:0]          pend_rdata;

   // operands and arithmetic
   logic [COORD_W-1:0]         op_col_ff, op_row_ff;
   logic signed [DISP_W-1:0]   op_u_ff, op_up_ff, op_l_ff, op_r_ff, op_n_ff, op_d_ff;
   logic [SPEED_W-1:0]         op_spd_ff;
   logic [DAMP_W-1:0]          op_dmp_ff;
   logic                       op_done_ff;
   logic [31:0]                cm1, rm1;

   logic signed [35:0]  lap_ff, base_ff;
   logic signed [52:0]  prod1_ff;
   logic signed [52:0]  rnd1;
   logic signed [39:0]  s_ff;
   logic signed [57:0]  prod2_ff;
   logic signed [57:0]  rnd2;
   logic signed [DISP_W-1:0] sat;

   logic                       rsp_valid_ff;
   logic [COORD_W-1:0]         rsp_col_ff, rsp_row_ff;
   logic signed [DISP_W-1:0]   rsp_next_ff, rsp_old_ff;
   logic                       rsp_done_ff;

   // geometry
   assign w_raw = 32'(width_ff);
   assign h_raw = 32'(height_ff);
   assign w_eff = (w_raw == 32'd0) ? 32'd1 :
                  ((w_raw > 32'(MAX_COLS)) ? 32'(MAX_COLS) : w_raw);
   assign h_eff = (h_raw == 32'd0) ? 32'd1 :
                  ((h_raw > 32'(MAX_ROWS)) ? 32'(MAX_ROWS) : h_raw);
   assign col32 = 32'(col_ff);
   assign row32 = 32'(row_ff);
   assign c32   = 32'(cur_c_ff);
   assign r32   = 32'(cur_r_ff);

   assign sts.has_upper = (r32 >= 32'd1);
   assign sts.has_left  = (r32 + 32'd1 == h_eff) && (c32 >= 32'd1);
   assign sts.has_last  = (r32 + 32'd1 == h_eff) && (c32 + 32'd1 == w_eff);
   assign sts.rsp_taken = rsp_valid_ff && rsp_ready;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (c32 + 32'd1 >= w_eff) begin
         col_in = '0;
         row_in = (r32 + 32'd1 >= h_eff) ? '0 : RW'(r32 + 32'd1);
      end else begin
         col_in = AW'(c32 + 32'd1);
         row_in = cur_r_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= GRID_DIM_RESET;
         height_ff <= GRID_DIM_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         if (csr_we && (csr_index == REG_GRID_WIDTH || csr_index == REG_GRID_HEIGHT)) begin
            if (csr_index == REG_GRID_WIDTH) begin
               width_ff <= csr_wdata;
            end else begin
               height_ff <= csr_wdata;
            end
            col_ff <= '0;
            row_ff <= '0;
         end else if (cmd.finish) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

   // accept cell, wrapping a stale position back to the origin
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         if (col32 >= w_eff || row32 >= h_eff) begin
            cur_c_ff <= '0;
            cur_r_ff <= '0;
         end else begin
            cur_c_ff <= col_ff;
            cur_r_ff <= row_ff;
         end
         cu_ff <= in_disp_now;
         cp_ff <= in_disp_before;
         cs_ff <= in_speed_sq;
         cd_ff <= in_damp_factor;
      end
      if (cmd.cap_cur) begin
         upper_c_ff <= $signed(upper_rdata);
         lower_c_ff <= $signed(lower_rdata);
         bef_c_ff   <= $signed(pend_rdata[PW-1 -: DISP_W]);
         spd_c_ff   <= pend_rdata[DAMP_W +: SPEED_W];
         dmp_c_ff   <= pend_rdata[DAMP_W-1:0];
      end
      if (cmd.cap_next) begin
         upper_c1_ff <= $signed(upper_rdata);
      end
      if (cmd.finish) begin
         prev2_cu_ff <= prev_cu_ff;
         prev_cu_ff  <= cu_ff;
         prev_cp_ff  <= cp_ff;
         prev_cs_ff  <= cs_ff;
         prev_cd_ff  <= cd_ff;
         prev_low_ff <= upper_c_ff;
      end
   end

   // line buffers
   assign raddr = cmd.rd_next ? AW'(c32 + 32'd1) : cur_c_ff;

   dws_ram #(.WIDTH(DISP_W), .DEPTH(MAX_COLS)) u_upper (
      .clock (clock),
      .we    (cmd.cap_next),
      .waddr (cur_c_ff),
      .wdata (cu_ff),
      .raddr (raddr),
      .rdata (upper_rdata)
   );

   dws_ram #(.WIDTH(DISP_W), .DEPTH(MAX_COLS)) u_lower (
      .clock (clock),
      .we    (cmd.cap_next),
      .waddr (cur_c_ff),
      .wdata (upper_c_ff),
      .raddr (raddr),
      .rdata (lower_rdata)
   );

   dws_ram #(.WIDTH(PW), .DEPTH(MAX_COLS)) u_pend (
      .clock (clock),
      .we    (cmd.cap_next),
      .waddr (cur_c_ff),
      .wdata ({cp_ff, cs_ff, cd_ff}),
      .raddr (raddr),
      .rdata (pend_rdata)
   );

   // operand selection
   assign cm1 = c32 - 32'd1;
   assign rm1 = r32 - 32'd1;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         unique case (cmd.job)
            JOB_UPPER: begin
               op_col_ff  <= c32[COORD_W-1:0];
               op_row_ff  <= rm1[COORD_W-1:0];
               op_u_ff    <= upper_c_ff;
               op_up_ff   <= bef_c_ff;
               op_spd_ff  <= spd_c_ff;
               op_dmp_ff  <= dmp_c_ff;
               op_l_ff    <= (c32 >= 32'd1) ? prev_low_ff : '0;
               op_r_ff    <= (c32 + 32'd1 < w_eff) ? upper_c1_ff : '0;
               op_n_ff    <= cu_ff;
               op_d_ff    <= (r32 >= 32'd2) ? lower_c_ff : '0;
               op_done_ff <= 1'b0;
            end
            JOB_LEFT: begin
               op_col_ff  <= cm1[COORD_W-1:0];
               op_row_ff  <= r32[COORD_W-1:0];
               op_u_ff    <= prev_cu_ff;
               op_up_ff   <= prev_cp_ff;
               op_spd_ff  <= prev_cs_ff;
               op_dmp_ff  <= prev_cd_ff;
               op_l_ff    <= (c32 >= 32'd2) ? prev2_cu_ff : '0;
               op_r_ff    <= cu_ff;
               op_n_ff    <= '0;
               op_d_ff    <= (r32 >= 32'd1) ? prev_low_ff : '0;
               op_done_ff <= 1'b0;
            end
            JOB_LAST: begin
               op_col_ff  <= c32[COORD_W-1:0];
               op_row_ff  <= r32[COORD_W-1:0];
               op_u_ff    <= cu_ff;
               op_up_ff   <= cp_ff;
               op_spd_ff  <= cs_ff;
               op_dmp_ff  <= cd_ff;
               op_l_ff    <= (c32 >= 32'd1) ? prev_cu_ff : '0;
               op_r_ff    <= '0;
               op_n_ff    <= '0;
               op_d_ff    <= (r32 >= 32'd1) ? upper_c_ff : '0;
               op_done_ff <= 1'b1;
            end
            default: begin
               op_done_ff <= 1'b0;
            end
         endcase
      end
   end

   // stencil arithmetic, registered at each step
   assign rnd1 = (prod1_ff + 53'sd32768) >>> 16;
   assign rnd2 = (prod2_ff + 58'sd32768) >>> 16;
   assign sat  = (rnd2 > 58'sd2147483647)  ? 32'sh7FFFFFFF :
                 (rnd2 < -58'sd2147483648) ? 32'sh80000000 : rnd2[DISP_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.lap) begin
         lap_ff  <= 36'(op_l_ff) + 36'(op_r_ff) + 36'(op_n_ff) + 36'(op_d_ff)
                    - (36'(op_u_ff) <<< 2);
         base_ff <= (36'(op_u_ff) <<< 1) - 36'(op_up_ff);
      end
      if (cmd.mul1) begin
         prod1_ff <= $signed({1'b0, op_spd_ff}) * lap_ff;
      end
      if (cmd.sum) begin
         s_ff <= 40'(base_ff) + 40'(rnd1);
      end
      if (cmd.mul2) begin
         prod2_ff <= s_ff * $signed({1'b0, op_dmp_ff});
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_col_ff  <= op_col_ff;
         rsp_row_ff  <= op_row_ff;
         rsp_next_ff <= sat;
         rsp_old_ff  <= op_u_ff;
         rsp_done_ff <= op_done_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_col   = rsp_col_ff;
   assign rsp_out_row   = rsp_row_ff;
   assign rsp_disp_next = rsp_next_ff;
   assign rsp_disp_old  = rsp_old_ff;
   assign rsp_grid_done = rsp_done_ff;
endmodule

### sim/damped_wave_stencil_2d_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// damped_wave_stencil_2d_tb
// Streams raster grids of cells through the wave stencil and checks every
// updated cell against an in-bench line-buffer predictor. Covers degenerate
// and extreme geometries, saturation, pass restarts, back-pressure and
// random idle gaps on both channels.
// ---------------------------------------------------------------------------
module damped_wave_stencil_2d_tb;
   import dws_pkg::*;

   typedef struct {
      logic [7:0]  col;
      logic [7:0]  row;
      logic [31:0] disp_next;
      logic [31:0] disp_old;
      logic        grid_done;
   } cell_update_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   dws_req_if req_ch ();
   dws_rsp_if rsp_ch ();

   damped_wave_stencil_2d DUT (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   cell_update_type expected_updates[$];
   int failures = 0;
   int cells_sent = 0;
   int updates_seen = 0;
   int passes_done = 0;
   bit calm = 1'b0;
   int hold_request = 0;

   // predictor state
   int grid_w_reg = 256;
   int grid_h_reg = 256;
   logic signed [31:0] upper_disp [256];
   logic signed [31:0] lower_disp [256];
   logic signed [31:0] pend_before [256];
   logic [15:0] pend_speed [256];
   logic [16:0] pend_damp [256];
   longint left_hold [2];
   int col_pos = 0;
   int row_pos = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic int clamp_dim(int v);
      if (v == 0) return 1;
      return (v > 256) ? 256 : v;
   endfunction

   function automatic longint round_q16(longint p);
      return (p + 32768) >>> 16;
   endfunction

   function automatic void add_update(int col, int row, longint u, longint u_prev,
                                      longint spd, longint dmp, longint lft,
                                      longint rgt, longint up, longint dn, bit done);
      cell_update_type e;
      longint lap, s, n;
      lap = rgt + lft + up + dn - 4 * u;
      s = 2 * u - u_prev + round_q16(spd * lap);
      n = round_q16(s * dmp);
      if (n > 64'sd2147483647) n = 64'sd2147483647;
      if (n < -64'sd2147483648) n = -64'sd2147483648;
      e.col = col[7:0];
      e.row = row[7:0];
      e.disp_next = n[31:0];
      e.disp_old = u[31:0];
      e.grid_done = done;
      expected_updates.push_back(e);
   endfunction

   function automatic void predict_cell(logic signed [31:0] u, logic signed [31:0] p,
                                        logic [15:0] s, logic [16:0] d);
      int w, h, c, r;
      longint cu, lft, rgt, dn;
      w = clamp_dim(grid_w_reg);
      h = clamp_dim(grid_h_reg);
      c = col_pos;
      r = row_pos;
      if (c >= w || r >= h) begin
         c = 0;
         r = 0;
      end
      cu = u;
      if (r >= 1) begin
         lft = (c >= 1) ? left_hold[0] : 0;
         rgt = (c + 1 < w) ? longint'(upper_disp[c + 1]) : 0;
         dn = (r >= 2) ? longint'(lower_disp[c]) : 0;
         add_update(c, r - 1, upper_disp[c], pend_before[c], pend_speed[c],
                    pend_damp[c], lft, rgt, cu, dn, 1'b0);
      end
      left_hold[0] = upper_disp[c];
      lower_disp[c] = upper_disp[c];
      upper_disp[c] = u;
      pend_before[c] = p;
      pend_speed[c] = s;
      pend_damp[c] = d;
      if (r + 1 == h) begin
         if (c >= 1) begin
            lft = (c >= 2) ? left_hold[1] : 0;
            dn = (r >= 1) ? longint'(lower_disp[c - 1]) : 0;
            add_update(c - 1, r, upper_disp[c - 1], pend_before[c - 1],
                       pend_speed[c - 1], pend_damp[c - 1], lft, cu, 0, dn, 1'b0);
         end
         if (c + 1 == w) begin
            lft = (c >= 1) ? longint'(upper_disp[c - 1]) : 0;
            dn = (r >= 1) ? longint'(lower_disp[c]) : 0;
            add_update(c, r, cu, p, s, d, lft, 0, 0, dn, 1'b1);
            passes_done++;
         end
      end
      left_hold[1] = (c >= 1) ? longint'(upper_disp[c - 1]) : 0;
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      col_pos = c;
      row_pos = r;
   endfunction

   function automatic logic [31:0] rand_disp();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000);
         2: return ($urandom_range(0, 1) == 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
      endcase
   endfunction

   function automatic logic [16:0] rand_damp();
      if ($urandom_range(0, 7) == 0) return 17'($urandom_range(65537, 131071));
      return 17'($urandom_range(0, 65536));
   endfunction

   function automatic int draw_wait();
      return calm ? 0 : $urandom_range(0, 19);
   endfunction

   task automatic send_cell(logic [31:0] u, logic [31:0] p, logic [15:0] s,
                            logic [16:0] d);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.disp_now <= u;
      req_ch.disp_before <= p;
      req_ch.speed_sq <= s;
      req_ch.damp_factor <= d;
      do @(posedge clock); while (!req_ch.ready);
      predict_cell(u, p, s, d);
      cells_sent++;
   endtask

   task automatic send_random_cell();
      send_cell(rand_disp(), rand_disp(), 16'($urandom_range(0, 65535)), rand_damp());
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_updates.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, int value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == REG_GRID_WIDTH) begin
         grid_w_reg = value & 9'h1FF;
         col_pos = 0;
         row_pos = 0;
      end else if (idx == REG_GRID_HEIGHT) begin
         grid_h_reg = value & 9'h1FF;
         col_pos = 0;
         row_pos = 0;
      end
   endtask

   task automatic set_grid(int w, int h);
      write_csr(REG_GRID_WIDTH, w);
      write_csr(REG_GRID_HEIGHT, h);
      @(posedge clock);
   endtask

   task automatic send_random_pass();
      int n;
      n = clamp_dim(grid_w_reg) * clamp_dim(grid_h_reg);
      repeat (n) send_random_cell();
   endtask

   task automatic test_single_cell_extremes();
      set_grid(0, 0);
      send_cell(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 17'h1FFFF);
      send_cell(32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 17'd65536);
      send_cell(32'h0000_0000, 32'h0000_0000, 16'h0000, 17'd0);
      send_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0000, 17'd65536);
      send_cell(32'h0001_8000, 32'hFFFF_4000, 16'h8000, 17'd32768);
      send_cell(32'hFFFF_FFFF, 32'h0000_0001, 16'h0001, 17'd1);
      wait_idle();
   endtask

   task automatic test_small_grid();
      set_grid(3, 3);
      send_cell(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 17'h1FFFF);
      send_cell(32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 17'd65536);
      send_cell(32'h7FFF_FFFF, 32'h0000_0000, 16'h0000, 17'd0);
      send_cell(32'h8000_0000, 32'h8000_0000, 16'hFFFF, 17'd65536);
      send_cell(32'h0001_0000, 32'h0000_8000, 16'h4000, 17'd65000);
      send_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 17'h1FFFF);
      send_cell(32'hFFFF_0000, 32'h0002_0000, 16'h1234, 17'd65536);
      send_cell(32'h8000_0000, 32'h0000_0000, 16'hFFFF, 17'h1FFFF);
      send_cell(32'h0000_0001, 32'hFFFF_FFFF, 16'h0001, 17'd65535);
      wait_idle();
   endtask

   task automatic test_widest_row();
      set_grid(511, 1);
      repeat (20) send_random_cell();
      wait_idle();
   endtask

   task automatic test_tallest_column();
      set_grid(1, 300);
      repeat (20) send_random_cell();
      wait_idle();
      set_grid(9, 2);
      send_random_pass();
      wait_idle();
   endtask

   task automatic test_back_pressure();
      set_grid(4, 4);
      hold_request++;
      send_random_pass();
      send_random_pass();
      wait_idle();
   endtask

   task automatic test_sender_pause();
      set_grid(5, 3);
      repeat (8) send_random_cell();
      wait_idle();
      repeat (7) send_random_cell();
      wait_idle();
   endtask

   task automatic test_random_grids();
      int start;
      start = cells_sent;
      while (cells_sent - start < 40) begin
         calm = ($urandom_range(0, 3) == 0);
         set_grid($urandom_range(1, 6), $urandom_range(1, 4));
         if ($urandom_range(0, 4) == 0) begin
            // abandon a pass part way, then restart it
            repeat ($urandom_range(1, clamp_dim(grid_w_reg) * clamp_dim(grid_h_reg)))
               send_random_cell();
            wait_idle();
            write_csr(REG_GRID_HEIGHT + 4'($urandom_range(1, 14)), $urandom_range(0, 511));
            write_csr(REG_GRID_WIDTH, grid_w_reg);
         end
         repeat ($urandom_range(1, 2)) send_random_pass();
         wait_idle();
      end
      calm = 1'b0;
   endtask

   // result side: random stalls, optional long hold-off
   always @(posedge clock) begin
      static int stall = 0;
      static int long_hold = 0;
      static int holds_served = 0;
      cell_update_type e;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (hold_request != holds_served) begin
            long_hold = 300;
            holds_served = hold_request;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            updates_seen++;
            if (expected_updates.size() == 0) begin
               $error("unexpected result col=%0d row=%0d", rsp_ch.out_col, rsp_ch.out_row);
               failures++;
            end else begin
               e = expected_updates.pop_front();
               if (rsp_ch.out_col !== e.col) begin
                  $error("out_col: expected %0d, got %0d", e.col, rsp_ch.out_col);
                  failures++;
               end
               if (rsp_ch.out_row !== e.row) begin
                  $error("out_row: expected %0d, got %0d", e.row, rsp_ch.out_row);
                  failures++;
               end
               if (rsp_ch.disp_next !== e.disp_next) begin
                  $error("disp_next: expected %h, got %h", e.disp_next, rsp_ch.disp_next);
                  failures++;
               end
               if (rsp_ch.disp_old !== e.disp_old) begin
                  $error("disp_old: expected %h, got %h", e.disp_old, rsp_ch.disp_old);
                  failures++;
               end
               if (rsp_ch.grid_done !== e.grid_done) begin
                  $error("grid_done: expected %0b, got %0b", e.grid_done, rsp_ch.grid_done);
                  failures++;
               end
            end
            stall = draw_wait();
         end else if (stall > 0) begin
            stall--;
         end
         if (long_hold > 0) long_hold--;
         rsp_ch.ready <= (stall == 0 && long_hold == 0);
      end
   end

   always @(posedge clock) begin
      static int quiet = 0;
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet = 0;
      else
         quiet++;
      if (quiet >= 2000) begin
         $display("Timeout: no item moved for %0d cycles", quiet);
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      req_ch.valid <= 1'b0;
      req_ch.disp_now <= '0;
      req_ch.disp_before <= '0;
      req_ch.speed_sq <= '0;
      req_ch.damp_factor <= '0;
      left_hold[0] = 0;
      left_hold[1] = 0;
      for (int i = 0; i < 256; i++) begin
         upper_disp[i] = '0;
         lower_disp[i] = '0;
         pend_before[i] = '0;
         pend_speed[i] = '0;
         pend_damp[i] = '0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_single_cell_extremes();
      test_small_grid();
      test_widest_row();
      test_tallest_column();
      test_back_pressure();
      test_sender_pause();
      test_random_grids();
      wait_idle();
      $display("Sent %0d cells, checked %0d updated cells over %0d complete grid passes.",
               cells_sent, updates_seen, passes_done);
      if (failures == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
